// ===== design/u8dec_pkg.sv =====
// Package for the UTF-8 code point decoder.
// Holds sequence length and remap constants, the decode helper functions
// and the types used by the modules.
package u8dec_pkg;

  localparam int ByteW = 8;
  localparam int CpW   = 31;
  localparam int LenW  = 3;

  // Legacy six-byte length table
  localparam logic [LenW-1:0] LenOne   = 3'd1;
  localparam logic [LenW-1:0] LenTwo   = 3'd2;
  localparam logic [LenW-1:0] LenThree = 3'd3;
  localparam logic [LenW-1:0] LenFour  = 3'd4;
  localparam logic [LenW-1:0] LenFive  = 3'd5;
  localparam logic [LenW-1:0] LenSix   = 3'd6;

  // Byte order mark as decoded value
  localparam logic [CpW-1:0] BomCp = 31'h0000_FEFF;

  // CP932-compatible remap pairs
  localparam logic [CpW-1:0] WaveDashCp      = 31'h0000_301C;
  localparam logic [CpW-1:0] FwTildeCp       = 31'h0000_FF5E;
  localparam logic [CpW-1:0] DoubleVertCp    = 31'h0000_2016;
  localparam logic [CpW-1:0] ParallelCp      = 31'h0000_2225;
  localparam logic [CpW-1:0] MinusSignCp     = 31'h0000_2212;
  localparam logic [CpW-1:0] FwHyphenCp      = 31'h0000_FF0D;
  localparam logic [CpW-1:0] CentCp          = 31'h0000_00A2;
  localparam logic [CpW-1:0] FwCentCp        = 31'h0000_FFE0;
  localparam logic [CpW-1:0] PoundCp         = 31'h0000_00A3;
  localparam logic [CpW-1:0] FwPoundCp       = 31'h0000_FFE1;
  localparam logic [CpW-1:0] NotSignCp       = 31'h0000_00AC;
  localparam logic [CpW-1:0] FwNotSignCp     = 31'h0000_FFE2;

  localparam logic [1:0] ContTag = 2'b10;

  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           char_present;
    logic           last_of_string;
  } result_t;

  typedef struct packed {
    logic    emit;
    result_t data;
  } step_t;

  function automatic logic [LenW-1:0] length_of(input logic [ByteW-1:0] b);
    logic [LenW-1:0] len;
    unique case (b) inside
      [8'hC0:8'hDF]: len = LenTwo;
      [8'hE0:8'hEF]: len = LenThree;
      [8'hF0:8'hF7]: len = LenFour;
      [8'hF8:8'hFB]: len = LenFive;
      [8'hFC:8'hFD]: len = LenSix;
      default:       len = LenOne;
    endcase
    return len;
  endfunction

  function automatic logic [ByteW-1:0] lead_bits(input logic [ByteW-1:0] b,
                                                 input logic [LenW-1:0]  len);
    logic [ByteW-1:0] bits;
    unique case (len)
      LenTwo:   bits = b & 8'h1F;
      LenThree: bits = b & 8'h0F;
      LenFour:  bits = b & 8'h07;
      LenFive:  bits = b & 8'h03;
      LenSix:   bits = b & 8'h01;
      default:  bits = b;
    endcase
    return bits;
  endfunction

  function automatic logic [CpW-1:0] remap(input logic [CpW-1:0] c);
    logic [CpW-1:0] r;
    unique case (c)
      WaveDashCp:   r = FwTildeCp;
      DoubleVertCp: r = ParallelCp;
      MinusSignCp:  r = FwHyphenCp;
      CentCp:       r = FwCentCp;
      PoundCp:      r = FwPoundCp;
      NotSignCp:    r = FwNotSignCp;
      default:      r = c;
    endcase
    return r;
  endfunction

endpackage

// ===== design/u8dec_if.sv =====
// Valid/ready channel interfaces for the UTF-8 decoder.
// Depends on u8dec_pkg for field widths.
interface u8dec_byte_if
  import u8dec_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] in_byte;
  logic             string_end;

  modport source (output valid, in_byte, string_end, input ready);
  modport sink   (input valid, in_byte, string_end, output ready);
endinterface

interface u8dec_cp_if
  import u8dec_pkg::*;
  ();
  logic           valid;
  logic           ready;
  logic [CpW-1:0] code_point;
  logic           char_present;
  logic           last_of_string;

  modport source (output valid, code_point, char_present, last_of_string, input ready);
  modport sink   (input valid, code_point, char_present, last_of_string, output ready);
endinterface

// ===== design/u8dec_assemble.sv =====
// Sequence assembly state and per-byte decode step.
// Depends on u8dec_pkg for length table, remap and the step_t type.
module u8dec_assemble
  import u8dec_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic [ByteW-1:0] in_byte,
  input  logic             string_end,
  output step_t            step
);

  logic [ByteW-1:0] lead_byte, lead_byte_next;
  logic [CpW-1:0]   payload, payload_next;
  logic [LenW-1:0]  bytes_seen, bytes_seen_next;
  logic [LenW-1:0]  seq_length, seq_length_next;
  logic             all_continuation, all_continuation_next;
  logic             at_string_start, at_string_start_next;

  logic             finish;
  logic             complete;
  logic             good;
  logic             drop;
  logic [CpW-1:0]   value;

  always_comb begin
    lead_byte_next        = lead_byte;
    payload_next          = payload;
    seq_length_next       = seq_length;
    all_continuation_next = all_continuation;
    at_string_start_next  = at_string_start;
    if (bytes_seen == '0) begin
      lead_byte_next        = in_byte;
      seq_length_next       = length_of(in_byte);
      payload_next          = {{(CpW-ByteW){1'b0}}, lead_bits(in_byte, seq_length_next)};
      all_continuation_next = 1'b1;
      bytes_seen_next       = LenW'(1);
    end else begin
      all_continuation_next = all_continuation && (in_byte[7:6] == ContTag);
      payload_next          = {payload[CpW-7:0], in_byte[5:0]};
      bytes_seen_next       = bytes_seen + LenW'(1);
    end

    complete = bytes_seen_next >= seq_length_next;
    finish   = complete || string_end;
    good     = complete && all_continuation_next;
    value    = good ? payload_next : {{(CpW-ByteW){1'b0}}, lead_byte_next};
    drop     = at_string_start && good && (seq_length_next == LenThree)
               && (payload_next == BomCp);

    // Close the sequence once its last byte or the string end arrives
    if (finish) begin
      bytes_seen_next      = '0;
      at_string_start_next = string_end;
    end

    step.emit = finish && (!drop || string_end);
    if (drop) begin
      step.data.code_point   = '0;
      step.data.char_present = 1'b0;
    end else begin
      step.data.code_point   = remap(value);
      step.data.char_present = 1'b1;
    end
    step.data.last_of_string = string_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_byte        <= '0;
      payload          <= '0;
      bytes_seen       <= '0;
      seq_length       <= '0;
      all_continuation <= 1'b1;
      at_string_start  <= 1'b1;
    end else if (advance) begin
      lead_byte        <= lead_byte_next;
      payload          <= payload_next;
      bytes_seen       <= bytes_seen_next;
      seq_length       <= seq_length_next;
      all_continuation <= all_continuation_next;
      at_string_start  <= at_string_start_next;
    end
  end

endmodule

// ===== design/utf8_codepoint_decoder_top.sv =====
// UTF-8 code point decoder, top level: one byte transaction in per cycle unless the output stalls.
// The result is registered at the edge that takes the finishing byte.
// Throughput: one byte per cycle while the output is taken; the output register frees as it is taken.
// Reset (rst, synchronous): clears the open sequence, marks string start, empties output.
// Depends on u8dec_pkg, u8dec_if and u8dec_assemble.
module utf8_codepoint_decoder_top
  import u8dec_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  u8dec_byte_if.sink  in_chan,
  u8dec_cp_if.source  out_chan
);

  step_t   step;
  logic    accept;
  logic    out_valid;
  result_t out_data;

  // Take a byte whenever the result register is empty or being drained now
  assign in_chan.ready = !out_valid || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;

  // Assembly state advances only on an accepted transaction
  u8dec_assemble u_assemble (
    .clk        (clk),
    .rst        (rst),
    .advance    (accept),
    .in_byte    (in_chan.in_byte),
    .string_end (in_chan.string_end),
    .step       (step)
  );

  // Result register: load a new result, otherwise drop the held one once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && step.emit) begin
      out_valid <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && step.emit) begin
      out_data <= step.data;
    end
  end

  assign out_chan.valid          = out_valid;
  assign out_chan.code_point     = out_data.code_point;
  assign out_chan.char_present   = out_data.char_present;
  assign out_chan.last_of_string = out_data.last_of_string;

endmodule
